// ===== rtl/gtpw_pkg.sv =====
// Shared types, constants and font lookup for the glyph text pixel writer.
`timescale 1ns / 1ps
`default_nettype none

package gtpw_pkg;

   // Field widths of the channels and the cursor.
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned X_W     = 12;
   localparam int unsigned Y_W     = 10;
   localparam int unsigned ROW_W   = 11;
   localparam int unsigned COL_W   = 13;
   localparam int unsigned LW_W    = 11;
   localparam int unsigned COLOR_W = 8;
   localparam int unsigned ADDR_W  = 21;
   localparam int unsigned GLYPH_W = 28;
   localparam int unsigned BIT_W   = 5;

   // Character set boundaries.
   localparam logic [CHAR_W-1:0] CHAR_A       = 8'd65;
   localparam logic [CHAR_W-1:0] LETTER_COUNT = 8'd26;
   localparam logic [CHAR_W-1:0] CHAR_0       = 8'd48;
   localparam logic [CHAR_W-1:0] DIGIT_COUNT  = 8'd10;

   // Cursor steps and limits.
   localparam logic [2:0]     ORIGIN_STEP = 3'd4;
   localparam logic [2:0]     GLYPH_STEP  = 3'd5;
   localparam logic [2:0]     BLANK_STEP  = 3'd4;
   localparam logic [X_W-1:0] X_MAX       = 12'd4095;
   localparam logic [Y_W-1:0] Y_MAX       = 10'd1023;
   localparam logic [2:0]     ROW_SPAN    = 3'd6;
   localparam logic [2:0]     COL_SPAN    = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [LW_W-1:0]    LINE_WIDTH_RESET = 11'd160;
   localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'd10;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_LINE_WIDTH = 1'b0,
      CSR_TEXT_COLOR = 1'b1
   } csr_index_type;

   // Input beat.
   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              first_of_string;
      logic [X_W-1:0]    origin_x;
      logic [Y_W-1:0]    origin_y;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [ADDR_W-1:0]  pixel_address;
      logic [COLOR_W-1:0] pixel_color;
      logic               last_pixel;
   } rsp_type;

   // Configuration values seen by the datapath.
   typedef struct packed {
      logic [LW_W-1:0]    line_width;
      logic [COLOR_W-1:0] text_color;
   } cfg_type;

   // One pixel position handed from the bit scanner to the address stage.
   typedef struct packed {
      logic             valid;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
   } pix_type;

   // Font: letters A-Z, then digits 0-9.
   localparam logic [GLYPH_W-1:0] GLYPH_ROM [0:35] = '{
      28'h699f999, 28'he99e99e, 28'h6988896, 28'he99999e, 28'hf88e88f, 28'hf88e888,
      28'h698b996, 28'h999f999, 28'h7222227, 28'h72222a4, 28'h9accaa9, 28'h888888f,
      28'h9ff9999, 28'h9ddbb99, 28'h6999996, 28'he99e888, 28'h69999b7, 28'he99ea99,
      28'h6986196, 28'h7222222, 28'h9999996, 28'h9999966, 28'h9999ff9, 28'h99fff99,
      28'h9996244, 28'hf12488f, 28'h69bd996, 28'h2622227, 28'h691248f, 28'h6916196,
      28'haaaf222, 28'hf88e11e, 28'h698e996, 28'hf112244, 28'h6996996, 28'h6997196
   };

   // Glyph word of a character; zero for a blank character.
   function automatic logic [GLYPH_W-1:0] glyph_word(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0]  letter_off;
      logic [CHAR_W-1:0]  digit_off;
      logic [GLYPH_W-1:0] word;
      letter_off = ch - CHAR_A;
      digit_off  = ch - CHAR_0;
      word       = '0;
      if (ch >= CHAR_A && letter_off < LETTER_COUNT) begin
         word = GLYPH_ROM[letter_off[5:0]];
      end else if (ch >= CHAR_0 && digit_off < DIGIT_COUNT) begin
         word = GLYPH_ROM[digit_off[5:0] + 6'd26];
      end
      return word;
   endfunction

   // Saturating add on the column cursor.
   function automatic logic [X_W-1:0] sat_add_x(input logic [X_W-1:0] a,
                                                input logic [2:0] inc);
      logic [X_W:0] sum;
      sum = {1'b0, a} + {{(X_W-2){1'b0}}, inc};
      return sum[X_W] ? X_MAX : sum[X_W-1:0];
   endfunction

   // Saturating add on the row cursor.
   function automatic logic [Y_W-1:0] sat_add_y(input logic [Y_W-1:0] a,
                                                input logic [2:0] inc);
      logic [Y_W:0] sum;
      sum = {1'b0, a} + {{(Y_W-2){1'b0}}, inc};
      return sum[Y_W] ? Y_MAX : sum[Y_W-1:0];
   endfunction

   // Index of the lowest set bit of a glyph word.
   function automatic logic [BIT_W-1:0] lowest_set(input logic [GLYPH_W-1:0] bits);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = GLYPH_W - 1; i >= 0; i--) begin
         if (bits[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gtpw_csr.sv =====
// Configuration registers: line width and text color.
`timescale 1ns / 1ps
`default_nettype none

module gtpw_csr (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_valid,
   output      logic                    csr_ready,
   input  wire gtpw_pkg::csr_index_type csr_index,
   input  wire logic [10:0]             csr_wdata,
   output      gtpw_pkg::cfg_type       cfg
);
   import gtpw_pkg::*;

   logic [LW_W-1:0]    line_width_ff;
   logic [COLOR_W-1:0] text_color_ff;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Register file update.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         text_color_ff <= TEXT_COLOR_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LINE_WIDTH: line_width_ff <= csr_wdata;
            CSR_TEXT_COLOR: text_color_ff <= csr_wdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.line_width = line_width_ff;
   assign cfg.text_color = text_color_ff;

endmodule

`default_nettype wire

// ===== rtl/gtpw_scan.sv =====
// Input stage: cursor tracking, font lookup and glyph bit scanner.
`timescale 1ns / 1ps
`default_nettype none

module gtpw_scan (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire gtpw_pkg::req_type req_data,
   input  wire logic              advance,
   output      gtpw_pkg::pix_type pix
);
   import gtpw_pkg::*;

   logic [GLYPH_W-1:0] bits_ff, bits_in;
   logic [X_W-1:0]     base_x_ff, base_x_in;
   logic [Y_W-1:0]     base_y_ff, base_y_in;
   logic [X_W-1:0]     cursor_x_ff, cursor_x_in;
   logic [Y_W-1:0]     cursor_y_ff, cursor_y_in;
   pix_type            pix_ff, pix_in;

   logic [GLYPH_W-1:0] rest;
   logic [BIT_W-1:0]   low_idx;
   logic               accept;
   logic [X_W-1:0]     start_x;
   logic [Y_W-1:0]     start_y;
   logic [GLYPH_W-1:0] word;

   always_comb begin
      // Bits left once the lowest one is sent on.
      rest    = bits_ff & (bits_ff - GLYPH_W'(1));
      low_idx = lowest_set(bits_ff);

      // A new beat enters when the pipe advances and the glyph in progress is on its last pixel or done.
      req_stall = !advance || (rest != '0);
      accept    = req_valid && !req_stall;

      // Cursor at the start of this character.
      start_x = req_data.first_of_string ? sat_add_x(req_data.origin_x, ORIGIN_STEP)
                                         : cursor_x_ff;
      start_y = req_data.first_of_string ? sat_add_y(req_data.origin_y, ORIGIN_STEP)
                                         : cursor_y_ff;
      word    = glyph_word(req_data.character);

      bits_in     = bits_ff;
      base_x_in   = base_x_ff;
      base_y_in   = base_y_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      pix_in      = pix_ff;

      // Send one set bit per cycle toward the address stage while the pipe advances.
      if (advance) begin
         bits_in      = rest;
         pix_in.valid = (bits_ff != '0);
         pix_in.row   = {1'b0, base_y_ff} + ROW_W'(ROW_SPAN) - ROW_W'(low_idx[4:2]);
         pix_in.col   = {1'b0, base_x_ff} + COL_W'(COL_SPAN) - COL_W'(low_idx[1:0]);
         pix_in.last  = (rest == '0);
      end

      // Load the next glyph and move the cursor.
      if (accept) begin
         bits_in     = word;
         base_x_in   = start_x;
         base_y_in   = start_y;
         cursor_y_in = start_y;
         if (word != '0) begin
            cursor_x_in = sat_add_x(start_x, GLYPH_STEP);
         end else begin
            cursor_x_in = sat_add_x(start_x, BLANK_STEP);
         end
      end
   end

   // Scanner and cursor state.
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff     <= '0;
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         pix_ff      <= '0;
      end else begin
         bits_ff     <= bits_in;
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         pix_ff      <= pix_in;
      end
   end

   // Glyph origin for the scan in progress.
   always_ff @(posedge clock) begin
      base_x_ff <= base_x_in;
      base_y_ff <= base_y_in;
   end

   assign pix = pix_ff;

endmodule

`default_nettype wire

// ===== rtl/gtpw_addr.sv =====
// Address stage: row times line width plus column, into the result register.
`timescale 1ns / 1ps
`default_nettype none

module gtpw_addr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gtpw_pkg::pix_type pix,
   input  wire gtpw_pkg::cfg_type cfg,
   output      logic              advance,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      gtpw_pkg::rsp_type rsp_data
);
   import gtpw_pkg::*;

   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [ROW_W+LW_W-1:0] product;

   // The whole pipe moves unless a result beat is held by the receiver.
   assign advance = !(rsp_valid_ff && rsp_stall);

   // Linear address, kept to its low bits.
   always_comb begin
      product                   = pix.row * cfg.line_width;
      rsp_data_in.pixel_address = product[ADDR_W-1:0] + ADDR_W'(pix.col);
      rsp_data_in.pixel_color   = cfg.text_color;
      rsp_data_in.last_pixel    = pix.last;
   end

   // Result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= pix.valid;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/glyph_text_pixel_writer.sv =====
// Top level of the glyph text pixel writer.
//
// Usage: each req beat carries one character and, on the first character of a
// string, the string origin. Letters A-Z and digits 0-9 produce one rsp beat
// per set pixel of their 4x7 glyph (up to 28), the last one flagged by
// last_pixel; any other character produces no beat and only moves the cursor.
// The csr channel writes line_width (index 0) and text_color (index 1); it is
// always ready and is meant to be written while no character is in flight.
// Throughput: one rsp beat per cycle unless rsp_stall holds a result beat. A
// glyph holds the input until its last set pixel is sent on, since the bit
// scanner hands on one pixel per cycle; a blank character does not hold it.
// A character's first pixel passes the glyph bit, pixel and result registers.
// Reset clears the cursor to 0,0, restores line_width 160 and text_color 10
// and drops any work in flight. While rsp_stall holds a result beat, the
// whole pipe freezes and req_stall is raised.
`timescale 1ns / 1ps
`default_nettype none

module glyph_text_pixel_writer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire gtpw_pkg::req_type       req_data,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      gtpw_pkg::rsp_type       rsp_data,
   input  wire logic                    csr_valid,
   output      logic                    csr_ready,
   input  wire gtpw_pkg::csr_index_type csr_index,
   input  wire logic [10:0]             csr_wdata
);
   import gtpw_pkg::*;

   cfg_type cfg;
   pix_type pix;
   logic    advance;

   // Configuration registers.
   gtpw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Cursor and glyph bit scanner.
   gtpw_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .advance   (advance),
      .pix       (pix)
   );

   // Address computation and result register.
   gtpw_addr u_addr (
      .clock     (clock),
      .reset     (reset),
      .pix       (pix),
      .cfg       (cfg),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
